[rtl/core/ilc_pkg.sv]
// Shared types and codes for the indexed list with compaction.
// No dependencies; imported by the cell and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package ilc_pkg;

    localparam int unsigned CAPACITY_DEF   = 256;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned USED_W   = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_SET    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cell update controls
    typedef struct packed {
        logic wr;     // load the write data
        logic shift;  // take the upper neighbor's entry
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/core/ilc_cell.sv]
// One storage cell of the list: holds a single entry, loads new data or
// takes its upper neighbor's entry on remove. Depends on ilc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ilc_cell #(
    parameter int unsigned DATA_WIDTH = ilc_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire ilc_pkg::t_cell_ctrl    i_ctrl,
    input  wire logic [DATA_WIDTH-1:0]  i_wdata,
    input  wire logic [DATA_WIDTH-1:0]  i_upper,
    output logic      [DATA_WIDTH-1:0]  o_data
);
    import ilc_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.wr) begin
            n_data = i_wdata;
        end else if (i_ctrl.shift) begin
            n_data = i_upper;
        end
    end

    // contents are undefined until written, so no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[rtl/core/indexed_list_with_compaction_top.sv]
// An accepted command's result is captured in the output register. Throughput: one
// command per cycle for every command unless output stalls; a remove shifts all later
// cells down by one in that same cycle through the neighbor links of the cell row.
// A new command is taken while a result waits, as long as the output is free or drains.
// Reset (synchronous, active low) empties the list and the output register;
// entry contents are undefined until written and are never read before that.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_with_compaction_top #(
    parameter int unsigned CAPACITY   = ilc_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = ilc_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [ilc_pkg::CMD_W-1:0]    i_command,
    input  wire logic [ilc_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [ilc_pkg::VAL_W-1:0] i_value_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [ilc_pkg::VAL_W-1:0]  o_value_out,
    output logic [ilc_pkg::STATUS_W-1:0]      o_status,
    output logic [ilc_pkg::USED_W-1:0]        o_entries_used
);
    import ilc_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;
    localparam logic [MW-1:0] CAP_M = MW'(CAPACITY);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_value_out;
    logic [STATUS_W-1:0]   r_status;
    logic [USED_W-1:0]     r_entries_used;

    logic                  accept;
    logic [MW-1:0]         pos_w;
    logic [MW-1:0]         count_w;
    logic [MW-1:0]         rd_w;
    logic                  in_range;
    logic                  full;
    logic                  empty;
    logic                  do_push;
    logic                  do_set;
    logic                  do_remove;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [VAL_W-1:0]      rd_ext;
    logic [VAL_W-1:0]      n_value;
    t_status               n_status;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    t_cell_ctrl            cell_ctrl [CAPACITY];
    logic [CAPACITY-1:0]   rd_sel;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pos_w    = MW'(i_position);
    assign count_w  = MW'(r_count);
    assign in_range = pos_w < count_w;
    assign full     = count_w == CAP_M;
    assign empty    = r_count == '0;
    assign rd_w     = (i_command == CMD_POP) ? (count_w - MW'(1)) : pos_w;

    assign do_push   = accept && (i_command == CMD_PUSH) && !full;
    assign do_set    = accept && (i_command == CMD_SET) && in_range;
    assign do_remove = accept && (i_command == CMD_REMOVE) && in_range;

    // storage and readout widths
    generate
        if (DATA_WIDTH <= VAL_W) begin : g_narrow
            assign wdata  = i_value_in[DATA_WIDTH-1:0];
            if (DATA_WIDTH < VAL_W) begin : g_sext
                assign rd_ext = {{(VAL_W - DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
            end else begin : g_same
                assign rd_ext = rd_data;
            end
        end else begin : g_wide
            assign wdata  = {{(DATA_WIDTH - VAL_W){i_value_in[VAL_W-1]}}, i_value_in};
            assign rd_ext = rd_data[VAL_W-1:0];
        end
    endgenerate

    // row of cells; each cell's upper neighbor feeds it on remove
    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            localparam logic [MW-1:0] IDX = MW'(gi);
            logic [DATA_WIDTH-1:0] upper;

            if (gi == CAPACITY - 1) begin : g_top
                assign upper = cell_data[gi];
            end else begin : g_mid
                assign upper = cell_data[gi + 1];
            end

            assign cell_ctrl[gi].wr    = (do_push && (count_w == IDX)) ||
                                         (do_set && (pos_w == IDX));
            assign cell_ctrl[gi].shift = do_remove && (IDX >= pos_w);
            assign rd_sel[gi]          = rd_w == IDX;

            ilc_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (cell_ctrl[gi]),
                .i_wdata (wdata),
                .i_upper (upper),
                .o_data  (cell_data[gi])
            );
        end
    endgenerate

    // one-hot and-or readout
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | (cell_data[i] & {DATA_WIDTH{rd_sel[i]}});
        end
    end

    always_comb begin
        n_count  = r_count;
        n_value  = '0;
        n_status = ST_OK;
        case (i_command)
            CMD_PUSH: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP: begin
                if (empty) begin
                    n_status = ST_RANGE;
                end else begin
                    n_count = r_count - CW'(1);
                    n_value = rd_ext;
                end
            end
            CMD_REMOVE: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_count = r_count - CW'(1);
                    n_value = rd_ext;
                end
            end
            CMD_GET: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    n_value = rd_ext;
                end
            end
            CMD_SET: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value_out    <= n_value;
            r_status       <= n_status;
            r_entries_used <= USED_W'(n_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value_out    = r_value_out;
    assign o_status       = r_status;
    assign o_entries_used = r_entries_used;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        MW'(r_count) <= CAP_M)
        else $error("entry count beyond capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the list");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_remove |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the list");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_value_out == '0))
        else $error("error transaction carries nonzero value");

    a_full_only_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_entries_used == USED_W'(CAPACITY)))
        else $error("full status below capacity");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for indexed_list_with_compaction_top.
// Depends on ilc_pkg and the top-level RTL; keeps its own list model for expected replies.
`timescale 1ns / 1ps

module tb_top;
    import ilc_pkg::*;

    localparam int LIST_SLOTS   = CAPACITY_DEF;
    localparam int MAX_GAP      = 18;
    localparam int CMD_MAX_CODE = (1 << CMD_W) - 1;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_WAIT  = 5;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
        logic [USED_W-1:0]       used;
    } t_list_reply;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    in_valid    = 1'b0;
    logic [CMD_W-1:0]        in_command  = '0;
    logic [POS_W-1:0]        in_position = '0;
    logic signed [VAL_W-1:0] in_value    = '0;
    logic                    out_ready   = 1'b1;

    logic                    o_in_ready;
    logic                    o_out_valid;
    logic signed [VAL_W-1:0] o_value_out;
    logic [STATUS_W-1:0]     o_status;
    logic [USED_W-1:0]       o_entries_used;

    // shadow copy of the list
    logic signed [VAL_W-1:0] list_mem [LIST_SLOTS];
    int                      list_len = 0;
    t_list_reply             pending_replies[$];

    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int          error_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          full_rejects = 0;
    int          range_rejects = 0;
    int          peak_len = 0;

    indexed_list_with_compaction_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (in_command),
        .i_position     (in_position),
        .i_value_in     (in_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_value_out    (o_value_out),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7 && list_len > 0)
            return POS_W'($urandom_range(0, list_len - 1));
        // one past the last entry is the usual off-by-one spot
        if (roll == 7 && list_len < LIST_SLOTS)
            return POS_W'(list_len);
        return POS_W'($urandom_range(0, LIST_SLOTS - 1));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 15);
        case (roll)
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Apply one command to the shadow list and queue the reply it should produce.
    task automatic predict_reply(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val);
        t_list_reply r;
        int          idx;
        r.value  = '0;
        r.status = ST_OK;
        idx      = int'(pos);
        case (cmd)
            CMD_PUSH: begin
                if (list_len >= LIST_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            CMD_POP: begin
                if (list_len == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    list_len--;
                    r.value = list_mem[list_len];
                end
            end
            CMD_REMOVE: begin
                if (idx >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.value = list_mem[idx];
                    for (int i = idx; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            CMD_GET: begin
                if (idx >= list_len)
                    r.status = ST_RANGE;
                else
                    r.value = list_mem[idx];
            end
            CMD_SET: begin
                if (idx >= list_len)
                    r.status = ST_RANGE;
                else
                    list_mem[idx] = val;
            end
            default: r.status = ST_RANGE;
        endcase
        r.used = list_len[USED_W-1:0];
        if (r.status == ST_FULL)
            full_rejects++;
        else if (r.status == ST_RANGE)
            range_rejects++;
        if (list_len > peak_len)
            peak_len = list_len;
        pending_replies.push_back(r);
    endtask

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        in_command  <= cmd;
        in_position <= pos;
        in_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predict_reply(cmd, pos, val);
        sent_count++;
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic send_random_cmd(input int grow_pct);
        int               roll;
        logic [CMD_W-1:0] cmd;
        roll = $urandom_range(0, 99);
        if (roll < grow_pct) begin
            cmd = CMD_PUSH;
        end else if (roll >= 97) begin
            cmd = CMD_W'($urandom_range(int'(CMD_SET) + 1, CMD_MAX_CODE));
        end else begin
            case ($urandom_range(0, 3))
                0: cmd = CMD_POP;
                1: cmd = CMD_REMOVE;
                2: cmd = CMD_GET;
                default: cmd = CMD_SET;
            endcase
        end
        send_cmd(cmd, pick_position(), pick_value());
    endtask

    task automatic test_empty_list();
        send_cmd(CMD_POP, '0, '0);
        send_cmd(CMD_REMOVE, '0, '0);
        send_cmd(CMD_GET, '0, '0);
        send_cmd(CMD_SET, '0, VAL_MAX);
        send_cmd(CMD_GET, '1, '0);
        for (int c = int'(CMD_SET) + 1; c <= CMD_MAX_CODE; c++)
            send_cmd(c[CMD_W-1:0], POS_W'($urandom), $urandom);
    endtask

    task automatic test_extremes_and_shift();
        send_cmd(CMD_PUSH, '0, VAL_MIN);
        send_cmd(CMD_PUSH, '0, VAL_MAX);
        send_cmd(CMD_PUSH, '0, '0);
        send_cmd(CMD_PUSH, '0, '1);
        send_cmd(CMD_PUSH, '0, 1);
        send_cmd(CMD_GET, 0, '0);
        send_cmd(CMD_GET, 4, '0);
        send_cmd(CMD_GET, 5, '0);          // one past the end
        send_cmd(CMD_SET, 2, VAL_MAX);
        send_cmd(CMD_GET, 2, '0);
        send_cmd(CMD_REMOVE, 1, '0);       // middle entry, tail shifts down
        send_cmd(CMD_GET, 1, '0);
        send_cmd(CMD_REMOVE, 3, '0);       // last entry, nothing to shift
        send_cmd(CMD_POP, '0, '0);
        send_cmd(CMD_POP, '0, '0);
        send_cmd(CMD_GET, 0, '0);
    endtask

    task automatic test_full_list();
        while (list_len < LIST_SLOTS)
            send_cmd(CMD_PUSH, POS_W'($urandom), pick_value());
        send_cmd(CMD_PUSH, '0, VAL_MIN);   // rejected, list full
        send_cmd(CMD_GET, '1, '0);
        send_cmd(CMD_SET, '1, VAL_MIN);
        send_cmd(CMD_REMOVE, '0, '0);      // whole row shifts
        send_cmd(CMD_GET, '0, '0);
        send_cmd(CMD_GET, '1, '0);
        send_cmd(CMD_PUSH, '0, VAL_MAX);
        send_cmd(CMD_POP, '0, '0);
        send_cmd(CMD_SET, '1, '0);
    endtask

    task automatic test_random_mix(input int n, input int grow_pct);
        repeat (n) send_random_cmd(grow_pct);
    endtask

    // output side: random stall after each accepted reply
    always @(posedge i_clk) begin
        if (o_out_valid && out_ready)
            stall_left = draw_gap(recv_calm);
        else if (stall_left != 0)
            stall_left--;
        out_ready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin : check_replies
        t_list_reply want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("reply with none expected: value=%0d status=%0d used=%0d",
                                          o_value_out, o_status, o_entries_used));
            end else begin
                want = pending_replies.pop_front();
                checked_count++;
                if (o_value_out !== want.value)
                    report_mismatch($sformatf("value_out got %0d want %0d",
                                              o_value_out, want.value));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", o_status, want.status));
                if (o_entries_used !== want.used)
                    report_mismatch($sformatf("entries_used got %0d want %0d",
                                              o_entries_used, want.used));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, pending_replies.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        drain_replies();
        test_extremes_and_shift();
        drain_replies();
        test_full_list();

        // back-to-back stretch, no idling on either side
        send_calm = 1'b1;
        recv_calm = 1'b1;
        test_random_mix(90, 45);
        send_calm = 1'b0;
        recv_calm = 1'b0;
        test_random_mix(110, 20);
        test_random_mix(180, 60);
        drain_replies();
        recv_calm = 1'b1;
        test_random_mix(110, 35);
        recv_calm = 1'b0;
        send_calm = 1'b1;
        test_random_mix(110, 30);
        send_calm = 1'b0;

        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Sent %0d commands, checked %0d replies; list depth peaked at %0d of %0d.",
                 sent_count, checked_count, peak_len, LIST_SLOTS);
        $display("Rejects seen: %0d list full, %0d empty or out of range; %0d mismatches.",
                 full_rejects, range_rejects, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
